@@ sv/block_transposition_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// block transposition cipher assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH
`define BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btc check failed");

// next-cycle implication
`define BTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btc check failed");

`else

`define BTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/btc_pkg.sv @@
// ----------------------------------------------------------------------------
// btc_pkg
// shared constants, types and helpers of the block transposition cipher
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int MAX_BLOCK   = 8;
    localparam int LANES       = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int KEY_W       = 3;
    localparam int CMP_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_BLOCK_SIZE  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD    = 3'd1;
    localparam logic [2:0] CFG_CIPHER_MODE = 3'd2;
    localparam logic [2:0] CFG_PAD_BYTE    = 3'd3;

    localparam logic [3:0]  RST_BLOCK_SIZE = 4'd8;
    localparam logic [23:0] RST_KEY_WORD   = 24'd16434824;
    localparam logic [7:0]  RST_PAD_BYTE   = 8'd88;

    localparam logic MODE_ENCRYPT = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [23:0]      key;
        logic             mode;
        logic [7:0]       pad;
    } t_cfg;

    typedef struct packed {
        logic [LANES-1:0][7:0] blk;
        logic [CNT_W-1:0]      fill;
        logic                  eom;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // block size clamped to 1..LANES
    function automatic logic [CNT_W-1:0] eff_size(input logic [3:0] bs);
        logic [CNT_W-1:0] n;
        if (bs == 4'd0) begin
            n = CNT_W'(1);
        end else if (bs > 4'(LANES)) begin
            n = CNT_W'(LANES);
        end else begin
            n = CNT_W'(bs);
        end
        return n;
    endfunction

endpackage

@@ sv/btc_front.sv @@
// ----------------------------------------------------------------------------
// btc_front
// gathers incoming bytes into a block and hands completed blocks to the queue
// ----------------------------------------------------------------------------
module btc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_message,
    input  btc_pkg::t_cfg        i_cfg,
    output logic                 o_q_push,
    output btc_pkg::t_entry      o_q_entry
);

    logic [btc_pkg::LANES-1:0][7:0] r_blk;
    logic [btc_pkg::LANES-1:0][7:0] n_blk;
    logic [btc_pkg::CNT_W-1:0]      r_fill;
    logic [btc_pkg::CNT_W-1:0]      n_fill;
    logic [btc_pkg::CNT_W-1:0]      pos;
    logic [btc_pkg::CNT_W-1:0]      new_fill;
    logic                           done;

    // a lowered block size clamps the write position to the last lane
    assign pos      = (r_fill >= i_cfg.n) ? (i_cfg.n - btc_pkg::CNT_W'(1)) : r_fill;
    assign new_fill = pos + btc_pkg::CNT_W'(1);
    assign done     = (new_fill == i_cfg.n) || i_end_of_message;

    always_comb begin
        n_blk = r_blk;
        for (int i = 0; i < btc_pkg::LANES; i++) begin
            if (i_accept && (btc_pkg::CNT_W'(i) == pos)) begin
                n_blk[i] = i_data_byte;
            end
        end
        n_fill = r_fill;
        if (i_accept) begin
            n_fill = done ? '0 : new_fill;
        end
    end

    assign o_q_push       = i_accept && done;
    assign o_q_entry.blk  = n_blk;
    assign o_q_entry.fill = new_fill;
    assign o_q_entry.eom  = i_end_of_message;

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

@@ sv/btc_queue.sv @@
// ----------------------------------------------------------------------------
// btc_queue
// short block queue between the gathering front and the emitting back
// ----------------------------------------------------------------------------
module btc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  btc_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output btc_pkg::t_entry   o_head,
    output btc_pkg::t_q_stat  o_stat
);

    btc_pkg::t_entry               r_mem [btc_pkg::QUEUE_DEPTH];
    logic [btc_pkg::QPTR_W-1:0]    r_wptr;
    logic [btc_pkg::QPTR_W-1:0]    r_rptr;
    logic [btc_pkg::QCNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    function automatic logic [btc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [btc_pkg::QPTR_W-1:0] p
    );
        logic [btc_pkg::QPTR_W-1:0] q;
        if (p == btc_pkg::QPTR_W'(btc_pkg::QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + btc_pkg::QPTR_W'(1);
        end
        return q;
    endfunction

    assign o_stat.full  = (r_count == btc_pkg::QCNT_W'(btc_pkg::QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + btc_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - btc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

@@ sv/btc_back.sv @@
// ----------------------------------------------------------------------------
// btc_back
// walks the head block one output position a cycle unless stalled, to the port
// ----------------------------------------------------------------------------
module btc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btc_pkg::t_cfg     i_cfg,
    input  btc_pkg::t_entry   i_head,
    input  btc_pkg::t_q_stat  i_q_stat,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_block,
    output logic              o_last_of_message
);

    logic [btc_pkg::LANE_W-1:0]     r_j;
    logic                           r_ovalid;
    logic [7:0]                     r_obyte;
    logic                           r_olob;
    logic                           r_olom;
    logic                           advance;
    logic                           last;
    logic [btc_pkg::CNT_W-1:0]      j_ext;
    logic [btc_pkg::KEY_W-1:0]      k;
    logic [btc_pkg::KEY_W-1:0]      ki;
    logic [btc_pkg::LANES-1:0][7:0] blk;
    logic [7:0]                     res;

    assign j_ext   = btc_pkg::CNT_W'(r_j);
    assign last    = (j_ext + btc_pkg::CNT_W'(1)) == i_cfg.n;
    assign advance = i_q_stat.valid && (!r_ovalid || i_pop);
    assign o_q_pop = advance && last;
    assign k       = i_cfg.key[btc_pkg::KEY_W*r_j +: btc_pkg::KEY_W];

    always_comb begin
        // lanes past the fill count read as pad
        for (int i = 0; i < btc_pkg::LANES; i++) begin
            blk[i] = (btc_pkg::CNT_W'(i) < i_head.fill) ? i_head.blk[i] : i_cfg.pad;
        end
        res = i_cfg.pad;
        ki  = '0;
        if (i_cfg.mode == btc_pkg::MODE_ENCRYPT) begin
            if (btc_pkg::CMP_W'(k) < btc_pkg::CMP_W'(i_cfg.n)) begin
                res = blk[k[btc_pkg::LANE_W-1:0]];
            end
        end else begin
            // highest block index naming this position wins
            for (int i = 0; i < btc_pkg::LANES; i++) begin
                ki = i_cfg.key[btc_pkg::KEY_W*i +: btc_pkg::KEY_W];
                if ((btc_pkg::CNT_W'(i) < i_cfg.n) && (ki == btc_pkg::KEY_W'(r_j))) begin
                    res = blk[i];
                end
            end
        end
    end

    assign o_empty           = !r_ovalid;
    assign o_out_byte        = r_obyte;
    assign o_last_of_block   = r_olob;
    assign o_last_of_message = r_olom;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= res;
            r_olob  <= last;
            r_olom  <= last && i_head.eom;
        end
        if (!i_rst_n) begin
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (advance) begin
                r_ovalid <= 1'b1;
                r_j      <= last ? '0 : r_j + btc_pkg::LANE_W'(1);
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/block_transposition_cipher.sv @@
// ----------------------------------------------------------------------------
// block_transposition_cipher
// gathers bytes into blocks and emits each block permuted by a packed key
// ----------------------------------------------------------------------------
// flow: a block enters the two-entry block queue on the cycle its last byte
//   (or end of message) is taken; the back registers its bytes in order
// throughput: one input byte and one output byte per cycle unless full or
//   the receiver stalls, set by the back walking one output position per cycle
// reset: synchronous active low; clears fill count, queue and output valid,
//   and loads block size 8, identity key, encrypt mode and pad 'X'
// ----------------------------------------------------------------------------
`include "block_transposition_cipher_assert.svh"

module block_transposition_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_block,
    output logic        o_last_of_message,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // configuration registers
    logic [3:0]        r_block_size;
    logic [23:0]       r_key_word;
    logic              r_cipher_mode;
    logic [7:0]        r_pad_byte;

    btc_pkg::t_cfg     cfg;
    btc_pkg::t_entry   q_in;
    btc_pkg::t_entry   q_head;
    btc_pkg::t_q_stat  q_stat;
    logic              q_push;
    logic              q_pop;
    logic              in_accept;

    // config writes are always taken, so the user must see they are only done while idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= btc_pkg::RST_BLOCK_SIZE;
            r_key_word    <= btc_pkg::RST_KEY_WORD;
            r_cipher_mode <= btc_pkg::MODE_ENCRYPT;
            r_pad_byte    <= btc_pkg::RST_PAD_BYTE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                btc_pkg::CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[3:0];
                btc_pkg::CFG_KEY_WORD:    r_key_word    <= i_cfg_data;
                btc_pkg::CFG_CIPHER_MODE: r_cipher_mode <= i_cfg_data[0];
                btc_pkg::CFG_PAD_BYTE:    r_pad_byte    <= i_cfg_data[7:0];
                default: ;  // unknown index, ignored
            endcase
        end
    end

    // effective settings shared by front and back
    assign cfg.n    = btc_pkg::eff_size(r_block_size);
    assign cfg.key  = r_key_word;
    assign cfg.mode = r_cipher_mode;
    assign cfg.pad  = r_pad_byte;

    // the front stalls only when the block queue has no free slot
    assign full      = q_stat.full;
    assign in_accept = push && !full;

    btc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_cfg            (cfg),
        .o_q_push         (q_push),
        .o_q_entry        (q_in)
    );

    // two slots: a completed block can wait while the previous one drains
    btc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // back drains the head block into the output register
    btc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_head            (q_head),
        .i_q_stat          (q_stat),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_out_byte        (o_out_byte),
        .o_last_of_block   (o_last_of_block),
        .o_last_of_message (o_last_of_message)
    );

    // a queued block reaches the output register without a bubble
    `BTC_ASSERT_NEXT(a_drain_starts, i_clk, i_rst_n, empty && q_stat.valid, !empty)
    // message end only ever closes a block
    `BTC_ASSERT_IMP(a_lom_has_lob, i_clk, i_rst_n, !empty && o_last_of_message, o_last_of_block)
    // backpressure only when blocks are actually waiting
    `BTC_ASSERT_IMP(a_full_has_blocks, i_clk, i_rst_n, full, q_stat.valid)
    // an accepted end of message always queues a block
    `BTC_ASSERT_NEXT(a_eom_queues, i_clk, i_rst_n, in_accept && i_end_of_message, q_stat.valid)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the block transposition cipher: bytes go in through
// the push side in random bursts, the bench keeps its own copy of the block
// store and the registers, works out every permuted byte whenever a block
// closes and checks the pop side against it in order
// ----------------------------------------------------------------------------
module tb_top;

    // run shape
    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT     = 200000;
    localparam int SHOWN_FAULTS  = 10;

    // register indexes past the last real one, writes there must be ignored
    localparam logic [2:0] CFG_SPARE_LO = 3'd4;
    localparam logic       MODE_DECRYPT = ~btc_pkg::MODE_ENCRYPT;

    // receiver stall styles
    typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS} t_stall;

    // one output byte as the pop side shows it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_block;
        logic       last_of_message;
    } t_cipher_byte;

    // dut ports, the inputs known from time zero
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        push             = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte      = 8'd0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_block;
    logic        o_last_of_message;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index      = 3'd0;
    logic [23:0] i_cfg_data       = 24'd0;

    // bench copy of the block state and registers
    logic [7:0]   held_bytes [btc_pkg::LANES];
    int unsigned  held_count;
    logic [3:0]   size_reg;
    logic [23:0]  key_reg;
    logic         mode_reg;
    logic [7:0]   pad_reg;

    // permuted bytes still owed by the dut, oldest first
    t_cipher_byte cipher_bytes_due [$];

    // bookkeeping
    int     fault_count    = 0;
    int     cycle_count    = 0;
    int     bytes_sent     = 0;
    int     bytes_checked  = 0;
    int     settings_used  = 0;
    int     decrypt_phases = 0;
    bit     gaps_on        = 1'b1;
    int     burst_left     = 0;
    t_stall stall_style    = STALL_COIN;
    int     run_left       = 0;
    logic   pop_run        = 1'b1;

    block_transposition_cipher uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_end_of_message  (i_end_of_message),
        .empty             (empty),
        .pop               (pop),
        .o_out_byte        (o_out_byte),
        .o_last_of_block   (o_last_of_block),
        .o_last_of_message (o_last_of_message),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycle_count, cipher_bytes_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // block size as the block uses it: zero reads as one, above the lanes
    // reads as the lane count
    function automatic int active_size();
        int n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > btc_pkg::LANES) n = btc_pkg::LANES;
        return n;
    endfunction

    function automatic void reset_cipher_state();
        held_count = 0;
        size_reg   = btc_pkg::RST_BLOCK_SIZE;
        key_reg    = btc_pkg::RST_KEY_WORD;
        mode_reg   = btc_pkg::MODE_ENCRYPT;
        pad_reg    = btc_pkg::RST_PAD_BYTE;
        foreach (held_bytes[j]) held_bytes[j] = 8'd0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [23:0] data);
        case (idx)
            btc_pkg::CFG_BLOCK_SIZE:  size_reg = data[3:0];
            btc_pkg::CFG_KEY_WORD:    key_reg  = data;
            btc_pkg::CFG_CIPHER_MODE: mode_reg = data[0];
            btc_pkg::CFG_PAD_BYTE:    pad_reg  = data[7:0];
            default: ;
        endcase
    endfunction

    // one accepted byte: store it, and when the block closes queue the
    // permuted block
    function automatic void gather_and_permute(input logic [7:0] d, input logic eom);
        int           n;
        int           pos;
        int           k;
        logic [7:0]   blk [btc_pkg::LANES];
        logic [7:0]   res [btc_pkg::LANES];
        t_cipher_byte c;
        n   = active_size();
        pos = held_count;
        // size lowered under a partly filled block: the byte lands on the last lane
        if (pos >= n) pos = n - 1;
        held_bytes[pos] = d;
        held_count      = pos + 1;
        if (held_count < n && !eom) return;
        for (int j = 0; j < n; j++) begin
            blk[j] = (j < held_count) ? held_bytes[j] : pad_reg;
            res[j] = pad_reg;
        end
        for (int j = 0; j < n; j++) begin
            k = key_reg[3*j +: 3];
            // key entries past the block are padded in encrypt, dropped in decrypt
            if (mode_reg == btc_pkg::MODE_ENCRYPT) begin
                if (k < n) res[j] = blk[k];
            end else begin
                if (k < n) res[k] = blk[j];
            end
        end
        for (int j = 0; j < n; j++) begin
            c.out_byte        = res[j];
            c.last_of_block   = (j == n - 1);
            c.last_of_message = (j == n - 1) && eom;
            cipher_bytes_due.push_back(c);
        end
        held_count = 0;
    endfunction

    function automatic void check_out_byte();
        t_cipher_byte got;
        t_cipher_byte want;
        got = '{o_out_byte, o_last_of_block, o_last_of_message};
        if (cipher_bytes_due.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS)
                $display("cycle %0d: unexpected byte %h lob %b lom %b", cycle_count,
                         got.out_byte, got.last_of_block, got.last_of_message);
            return;
        end
        want = cipher_bytes_due.pop_front();
        bytes_checked++;
        if (got.out_byte !== want.out_byte || got.last_of_block !== want.last_of_block
                || got.last_of_message !== want.last_of_message) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS)
                $display("cycle %0d: expected byte %h lob %b lom %b, got %h %b %b",
                         cycle_count, want.out_byte, want.last_of_block,
                         want.last_of_message, got.out_byte, got.last_of_block,
                         got.last_of_message);
        end
    endfunction

    // every handshake is seen here with the values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_out_byte();
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (push && !full) gather_and_permute(i_data_byte, i_end_of_message);
        end
    end

    // receiver: pops always, by coin toss, or in runs of pops and stalls
    always @(posedge i_clk) begin
        case (stall_style)
            STALL_NONE: pop <= 1'b1;
            STALL_COIN: pop <= 1'($urandom_range(1, 0));
            default: begin
                if (run_left == 0) begin
                    pop_run  = !pop_run;
                    run_left = $urandom_range(12, 1);
                end else begin
                    run_left--;
                end
                pop <= pop_run;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // drivers, every task starts and ends right after a rising edge
    // ------------------------------------------------------------------------

    // one byte request, with a random gap when gaps are on and the burst runs out
    task automatic send_byte(input logic [7:0] d, input logic eom);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(8, 1);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(16, 1);
        end
        if (burst_left > 0) burst_left--;
        push             <= 1'b1;
        i_data_byte      <= d;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop pushing, let every owed byte come out, then allow the pipe to settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (cipher_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [3:0] bs, input logic [23:0] key,
                             input logic mode, input logic [7:0] pad);
        write_reg(btc_pkg::CFG_BLOCK_SIZE, {20'd0, bs});
        write_reg(btc_pkg::CFG_KEY_WORD, key);
        write_reg(btc_pkg::CFG_CIPHER_MODE, {23'd0, mode});
        write_reg(btc_pkg::CFG_PAD_BYTE, {16'd0, pad});
        settings_used++;
    endtask

    // valid permutation over the first n entries, random junk above them
    function automatic logic [23:0] shuffled_key(input int n);
        logic [2:0]  lane [btc_pkg::LANES];
        logic [2:0]  swap;
        logic [23:0] key;
        int          r;
        for (int j = 0; j < btc_pkg::LANES; j++) lane[j] = 3'(j);
        for (int j = n - 1; j > 0; j--) begin
            r       = $urandom_range(j, 0);
            swap    = lane[j];
            lane[j] = lane[r];
            lane[r] = swap;
        end
        key = 24'($urandom);
        for (int j = 0; j < n; j++) key[3*j +: 3] = lane[j];
        return key;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: size 8, identity key, encrypt, pad 'X'
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b0);
        // short final block, six pad bytes
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // size zero acts as one, size fifteen as eight
    task automatic test_size_clamp();
        write_all(4'd0, btc_pkg::RST_KEY_WORD, btc_pkg::MODE_ENCRYPT, 8'h00);
        send_byte(8'h3c, 1'b0);
        wait_idle();
        write_all(4'd15, shuffled_key(btc_pkg::LANES), MODE_DECRYPT, 8'hff);
        send_byte(8'hc3, 1'b1);
        wait_idle();
    endtask

    // three bytes held at size four, then size two: next byte closes a block of two
    task automatic test_size_lowered_mid_block();
        write_all(4'd4, btc_pkg::RST_KEY_WORD, btc_pkg::MODE_ENCRYPT, 8'h11);
        send_byte(8'ha1, 1'b0);
        send_byte(8'ha2, 1'b0);
        send_byte(8'ha3, 1'b0);
        wait_idle();
        write_reg(btc_pkg::CFG_BLOCK_SIZE, 24'd2);
        send_byte(8'ha4, 1'b0);
        wait_idle();
    endtask

    // encrypt with entry 0 out of the block: that position takes the pad
    task automatic test_bad_key_encrypt();
        write_all(4'd3, {15'd0, 3'd0, 3'd2, 3'd7}, btc_pkg::MODE_ENCRYPT, 8'h5a);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b1);
        wait_idle();
    endtask

    // decrypt with two entries naming lane 1 and one out of range:
    // the higher block index wins, the stray byte is dropped, gaps get the pad
    task automatic test_bad_key_decrypt();
        write_all(4'd4, {12'd0, 3'd0, 3'd6, 3'd1, 3'd1}, MODE_DECRYPT, 8'ha5);
        send_byte(8'h31, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h34, 1'b0);
        wait_idle();
    endtask

    // writes past the last register must leave every setting alone
    task automatic test_spare_index();
        for (int j = 0; j < 4; j++)
            write_reg(CFG_SPARE_LO + 3'(j), 24'hffffff);
        send_byte(8'h99, 1'b1);
        wait_idle();
    endtask

    // random settings per phase, mostly whole messages with random content
    task automatic test_random_stream();
        int          start;
        int          phase;
        int          target;
        int          in_phase;
        int          n;
        int          msg_len;
        logic [3:0]  bs;
        logic [23:0] key;
        logic        mode;
        logic [7:0]  pad;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            // extremes first, then random settings
            if (phase == 0) begin
                bs = 4'd1; key = 24'h000000; mode = btc_pkg::MODE_ENCRYPT; pad = 8'h00;
            end else if (phase == 1) begin
                bs = 4'd8; key = 24'hffffff; mode = MODE_DECRYPT; pad = 8'hff;
            end else begin
                case ($urandom_range(9, 0))
                    0:       bs = 4'd0;
                    1:       bs = 4'($urandom_range(15, 9));
                    default: bs = 4'($urandom_range(8, 1));
                endcase
                key  = ($urandom_range(4, 0) == 0) ? 24'($urandom)
                                                   : shuffled_key(bs < 1 ? 1 : (bs > 8 ? 8 : bs));
                mode = 1'($urandom_range(1, 0));
                pad  = 8'($urandom);
            end
            // upper data bits of the size write are not part of the register
            write_reg(btc_pkg::CFG_BLOCK_SIZE,
                      {($urandom_range(1, 0) ? 20'($urandom) : 20'd0), bs});
            write_reg(btc_pkg::CFG_KEY_WORD, key);
            write_reg(btc_pkg::CFG_CIPHER_MODE, {23'd0, mode});
            write_reg(btc_pkg::CFG_PAD_BYTE, {16'd0, pad});
            settings_used++;
            if (mode == MODE_DECRYPT) decrypt_phases++;
            if ($urandom_range(9, 0) == 0)
                write_reg(CFG_SPARE_LO + 3'($urandom_range(3, 0)), 24'($urandom));

            gaps_on     = ($urandom_range(3, 0) != 0);
            stall_style = t_stall'($urandom_range(2, 0));
            n           = active_size();
            target      = $urandom_range(48, 16);
            in_phase    = 0;
            while (in_phase < target) begin
                if ($urandom_range(99, 0) < 85) begin
                    msg_len = $urandom_range(3 * n, 1);
                    for (int j = 0; j < msg_len; j++)
                        send_byte(8'($urandom), j == msg_len - 1);
                end else begin
                    // noise: end of message at random
                    msg_len = $urandom_range(10, 1);
                    for (int j = 0; j < msg_len; j++)
                        send_byte(8'($urandom), $urandom_range(3, 0) == 0);
                end
                in_phase += msg_len;
            end
            // sometimes leave a partial block for the next settings to close
            if ($urandom_range(9, 0) < 3) begin
                msg_len = $urandom_range(3, 1);
                for (int j = 0; j < msg_len; j++) send_byte(8'($urandom), 1'b0);
            end
            wait_idle();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_cipher_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_size_clamp();
        test_size_lowered_mid_block();
        test_bad_key_encrypt();
        test_bad_key_decrypt();
        test_spare_index();
        test_random_stream();

        wait_idle();
        $display("covered %0d input bytes and %0d checked output bytes over %0d settings",
                 bytes_sent, bytes_checked, settings_used);
        $display("%0d decrypt phases, clamped sizes, bad keys, spare indexes, %0d faults",
                 decrypt_phases, fault_count);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
